FILE: src/wlpd_pkg.sv
// Shared types and constants for the windowed level presence detector.
package wlpd_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned LEVEL_W  = 12;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LEVEL_W-1:0] ACTIVE_LEVEL_RST   = 12'd2048;
    localparam logic [LEVEL_W-1:0] INACTIVE_LEVEL_RST = 12'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE_LEVEL = 1'd1;

    typedef enum logic [1:0] {
        ST_INACTIVE = 2'd0,
        ST_ACTIVE   = 2'd1,
        ST_NOISE    = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_ACTIVE   = 2'd1,
        EV_INACTIVE = 2'd2,
        EV_NOISY    = 2'd3
    } t_event;

endpackage

FILE: src/wlpd_if.sv
// Request and result channel interfaces of the windowed level presence detector.
interface wlpd_req_if;
    logic                             valid;
    logic                             ready;
    logic [wlpd_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wlpd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  station_state;
    logic [1:0]  transition_event;
    logic        window_full;

    modport source (output valid, output station_state, output transition_event,
                    output window_full, input ready);
    modport sink   (input valid, input station_state, input transition_event,
                    input window_full, output ready);
endinterface

FILE: src/windowed_level_presence_detector_unit.sv
// Windowed level presence detector: moving-average level check with hysteresis.
//
// Takes one level sample per request and returns one result per request: the
// station state (inactive, active, noise), the transition event, and whether
// WINDOW samples have been seen. A new request is accepted every clock cycle
// unless results back up; a request passes the request register, then the
// result register. Between those registers sits the running-sum update
// (subtract the sample leaving the window, add the new one) and two compares
// against threshold * WINDOW, which are precomputed when a threshold is
// written. The window is a shift line of WINDOW taps; only the low SAMPLE_BITS
// bits of each sample are used. Write thresholds only while no request is in flight.
module windowed_level_presence_detector_unit #(
    parameter int unsigned WINDOW      = 16,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wlpd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wlpd_pkg::LEVEL_W-1:0]         i_cfg_data,
    wlpd_req_if.sink                             i_req,
    wlpd_res_if.source                           o_res
);

    localparam int unsigned SW     = (SAMPLE_BITS < wlpd_pkg::SAMPLE_W) ?
                                     SAMPLE_BITS : wlpd_pkg::SAMPLE_W;
    localparam int unsigned WB     = $clog2(WINDOW);
    localparam int unsigned SUM_W  = SW + WB;
    localparam int unsigned SCL_W  = wlpd_pkg::LEVEL_W + WB;
    localparam int unsigned CMP_W  = (SUM_W > SCL_W) ? SUM_W : SCL_W;
    localparam int unsigned FILL_W = $clog2(WINDOW + 1);

    // pipeline control
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_adv;
    logic w_acc;

    // request register
    logic [SW-1:0] r_in_sample;

    // detector state
    logic [SW-1:0]     r_win [WINDOW];
    logic [SUM_W-1:0]  r_sum;
    logic [FILL_W-1:0] r_fill;
    wlpd_pkg::t_state  r_state;
    logic [SCL_W-1:0]  r_act_scaled;
    logic [SCL_W-1:0]  r_inact_scaled;

    // result register
    wlpd_pkg::t_state  r_out_state;
    wlpd_pkg::t_event  r_out_ev;
    logic              r_out_full;

    // next values
    logic              w_was_full;
    logic [SW-1:0]     w_oldest;
    logic [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0] n_fill;
    logic              w_full;
    logic              w_hi;
    logic              w_lo;
    logic              w_noisy;
    wlpd_pkg::t_state  n_state;
    wlpd_pkg::t_event  n_ev;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_acc       = i_req.valid && i_req.ready;

    assign o_res.valid            = r_out_valid;
    assign o_res.station_state    = r_out_state;
    assign o_res.transition_event = r_out_ev;
    assign o_res.window_full      = r_out_full;

    // running sum and fill tracking; the oldest tap only counts once it holds a sample
    assign w_was_full = (r_fill == FILL_W'(WINDOW));
    assign w_oldest   = w_was_full ? r_win[WINDOW-1] : '0;
    assign n_sum      = r_sum - SUM_W'(w_oldest) + SUM_W'(r_in_sample);
    assign n_fill     = w_was_full ? r_fill : r_fill + FILL_W'(1);
    assign w_full     = (n_fill == FILL_W'(WINDOW));

    assign w_hi    = CMP_W'(n_sum) >= CMP_W'(r_act_scaled);
    assign w_lo    = CMP_W'(n_sum) <= CMP_W'(r_inact_scaled);
    assign w_noisy = w_full && !w_hi && !w_lo;

    always_comb begin
        n_state = wlpd_pkg::ST_INACTIVE;
        n_ev    = wlpd_pkg::EV_NONE;
        case (r_state)
            wlpd_pkg::ST_ACTIVE: begin
                n_state = wlpd_pkg::ST_ACTIVE;
                if (!w_full || w_lo) begin
                    n_state = wlpd_pkg::ST_INACTIVE;
                    n_ev    = wlpd_pkg::EV_INACTIVE;
                end else if (w_noisy) begin
                    n_state = wlpd_pkg::ST_NOISE;
                    n_ev    = wlpd_pkg::EV_NOISY;
                end
            end
            wlpd_pkg::ST_NOISE: begin
                n_state = wlpd_pkg::ST_NOISE;
                if (!w_noisy) begin
                    n_state = wlpd_pkg::ST_INACTIVE;
                    n_ev    = wlpd_pkg::EV_INACTIVE;
                end
            end
            default: begin
                // unused code falls back to inactive
                if (w_full && w_hi) begin
                    n_state = wlpd_pkg::ST_ACTIVE;
                    n_ev    = wlpd_pkg::EV_ACTIVE;
                end else if (w_noisy) begin
                    n_state = wlpd_pkg::ST_NOISE;
                    n_ev    = wlpd_pkg::EV_NOISY;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_sum          <= '0;
            r_fill         <= '0;
            r_state        <= wlpd_pkg::ST_INACTIVE;
            r_act_scaled   <= SCL_W'(wlpd_pkg::ACTIVE_LEVEL_RST) * SCL_W'(WINDOW);
            r_inact_scaled <= SCL_W'(wlpd_pkg::INACTIVE_LEVEL_RST) * SCL_W'(WINDOW);
        end else begin
            if (w_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_adv) begin
                r_sum   <= n_sum;
                r_fill  <= n_fill;
                r_state <= n_state;
            end

            // hold thresholds pre-scaled by the window length
            if (i_cfg_we && i_cfg_idx == wlpd_pkg::CFG_ACTIVE_LEVEL) begin
                r_act_scaled <= SCL_W'(i_cfg_data) * SCL_W'(WINDOW);
            end
            if (i_cfg_we && i_cfg_idx == wlpd_pkg::CFG_INACTIVE_LEVEL) begin
                r_inact_scaled <= SCL_W'(i_cfg_data) * SCL_W'(WINDOW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_sample <= i_req.sample[SW-1:0];
        end
        if (w_adv) begin
            r_win[0] <= r_in_sample;
            for (int k = 1; k < WINDOW; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_out_state <= n_state;
            r_out_ev    <= n_ev;
            r_out_full  <= w_full;
        end
    end

    a_full_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_full |-> r_fill == FILL_W'(WINDOW))
        else $error("window_full reported with fill count below window length");

    a_noise_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_state == wlpd_pkg::ST_NOISE |-> r_out_full)
        else $error("noise state reported with window not full");

    a_active_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wlpd_pkg::ST_ACTIVE |-> r_fill == FILL_W'(WINDOW))
        else $error("active state with window not full");

    a_event_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ev == wlpd_pkg::EV_ACTIVE |->
        r_out_state == wlpd_pkg::ST_ACTIVE)
        else $error("became-active event without active state");

    a_result_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_state == r_state)
        else $error("result state differs from detector state");

endmodule

FILE: sim/wlpd_presence_monitor.sv
// Presence detector monitor: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps

module wlpd_presence_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wlpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wlpd_pkg::LEVEL_W-1:0]   i_cfg_data,
    wlpd_req_if                            req_ch,
    wlpd_res_if                            res_ch,
    output int                             o_miss_count,
    output int                             o_outstanding
);

    localparam int unsigned DEPTH = 16;

    typedef struct packed {
        wlpd_pkg::t_state st;
        wlpd_pkg::t_event ev;
        logic             full;
    } t_presence;

    logic [wlpd_pkg::SAMPLE_W-1:0] level_window [DEPTH];
    logic [3:0]                    window_pos;
    logic [15:0]                   level_sum;
    logic [4:0]                    fill_level;
    wlpd_pkg::t_state              presence_state;
    logic [wlpd_pkg::LEVEL_W-1:0]  act_thresh;
    logic [wlpd_pkg::LEVEL_W-1:0]  inact_thresh;
    t_presence                     expected_states [$];
    int                            miss_count = 0;

    function automatic t_presence advance_presence(input logic [wlpd_pkg::SAMPLE_W-1:0] smp);
        t_presence r;
        logic      full;
        logic      hi;
        logic      lo;
        logic      noisy;
        // drop the oldest sample from the running sum, then take in the new one
        level_sum                = level_sum - 16'(level_window[window_pos]) + 16'(smp);
        level_window[window_pos] = smp;
        window_pos               = window_pos + 4'd1;
        if (fill_level < 5'(DEPTH)) begin
            fill_level = fill_level + 5'd1;
        end
        full  = (fill_level == 5'(DEPTH));
        hi    = (level_sum >= {act_thresh, 4'b0000});
        lo    = (level_sum <= {inact_thresh, 4'b0000});
        noisy = full && !hi && !lo;
        r.ev  = wlpd_pkg::EV_NONE;
        case (presence_state)
            wlpd_pkg::ST_ACTIVE: begin
                if (!full || lo) begin
                    presence_state = wlpd_pkg::ST_INACTIVE;
                    r.ev           = wlpd_pkg::EV_INACTIVE;
                end else if (noisy) begin
                    presence_state = wlpd_pkg::ST_NOISE;
                    r.ev           = wlpd_pkg::EV_NOISY;
                end
            end
            wlpd_pkg::ST_NOISE: begin
                if (!noisy) begin
                    presence_state = wlpd_pkg::ST_INACTIVE;
                    r.ev           = wlpd_pkg::EV_INACTIVE;
                end
            end
            default: begin
                presence_state = wlpd_pkg::ST_INACTIVE;
                if (full && hi) begin
                    presence_state = wlpd_pkg::ST_ACTIVE;
                    r.ev           = wlpd_pkg::EV_ACTIVE;
                end else if (noisy) begin
                    presence_state = wlpd_pkg::ST_NOISE;
                    r.ev           = wlpd_pkg::EV_NOISY;
                end
            end
        endcase
        r.st   = presence_state;
        r.full = full;
        return r;
    endfunction

    task automatic note_miss(input string what, input t_presence exp);
        miss_count = miss_count + 1;
        if (miss_count <= 10) begin
            $display("%0t: %s: expected state %0d event %0d full %0d,",
                     $realtime, what, exp.st, exp.ev, exp.full);
            $display("    got state %0d event %0d full %0d",
                     res_ch.station_state, res_ch.transition_event, res_ch.window_full);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_presence exp;
        int        k;
        if (!i_rst_n) begin
            for (k = 0; k < DEPTH; k++) begin
                level_window[k] = '0;
            end
            window_pos     = '0;
            level_sum      = '0;
            fill_level     = '0;
            presence_state = wlpd_pkg::ST_INACTIVE;
            act_thresh     = wlpd_pkg::ACTIVE_LEVEL_RST;
            inact_thresh   = wlpd_pkg::INACTIVE_LEVEL_RST;
            expected_states.delete();
        end else begin
            // check first: a result can never belong to the request of the same edge
            if (res_ch.valid && res_ch.ready) begin
                if (expected_states.size() == 0) begin
                    exp = '0;
                    note_miss("result with no request outstanding", exp);
                end else begin
                    exp = expected_states.pop_front();
                    if (res_ch.station_state !== exp.st ||
                        res_ch.transition_event !== exp.ev ||
                        res_ch.window_full !== exp.full) begin
                        note_miss("result mismatch", exp);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wlpd_pkg::CFG_ACTIVE_LEVEL:   act_thresh   = i_cfg_data;
                    wlpd_pkg::CFG_INACTIVE_LEVEL: inact_thresh = i_cfg_data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                expected_states.push_back(advance_presence(req_ch.sample));
            end
        end
        o_miss_count  = miss_count;
        o_outstanding = expected_states.size();
    end

endmodule

FILE: sim/windowed_level_presence_detector_unit_tb.sv
// Testbench top: drives samples and threshold writes, paces results, gives the verdict.
`timescale 1ns / 100ps

module windowed_level_presence_detector_unit_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 210;
    localparam int NUM_PHASES    = 8;
    localparam int STALL_AT      = 400;
    localparam int STALL_CYCLES  = 150;

    localparam logic [wlpd_pkg::LEVEL_W-1:0] ACT_SET [6] =
        '{12'd3000, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1000};
    localparam logic [wlpd_pkg::LEVEL_W-1:0] INACT_SET [6] =
        '{12'd2990, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd3000};

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [wlpd_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [wlpd_pkg::LEVEL_W-1:0]   i_cfg_data;

    int                             miss_count;
    int                             outstanding;
    int                             items_sent = 0;
    int                             cycle_count = 0;

    logic [wlpd_pkg::LEVEL_W-1:0]   cur_act;
    logic [wlpd_pkg::LEVEL_W-1:0]   cur_inact;
    int                             run_left = 0;
    int                             run_mode;
    int                             run_target;

    wlpd_req_if sample_ch ();
    wlpd_res_if state_ch ();

    windowed_level_presence_detector_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (sample_ch),
        .o_res      (state_ch)
    );

    wlpd_presence_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .req_ch        (sample_ch),
        .res_ch        (state_ch),
        .o_miss_count  (miss_count),
        .o_outstanding (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    // runs of samples around a target level, mostly at or between the thresholds, with noise and extreme runs mixed in
    function automatic logic [wlpd_pkg::SAMPLE_W-1:0] next_level();
        int v;
        if (run_left == 0) begin
            run_left = $urandom_range(6, 40);
            run_mode = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0:       run_target = int'(cur_act);
                1:       run_target = int'(cur_inact);
                2:       run_target = (int'(cur_act) + int'(cur_inact)) / 2;
                3:       run_target = int'($urandom_range(0, 4095));
                default: run_target = ($urandom_range(0, 1) != 0) ? 4095 : 0;
            endcase
        end
        run_left = run_left - 1;
        if (run_mode < 7) begin
            v = run_target + int'($urandom_range(0, 96)) - 48;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            return v[wlpd_pkg::SAMPLE_W-1:0];
        end else if (run_mode < 9) begin
            return wlpd_pkg::SAMPLE_W'($urandom_range(0, 4095));
        end
        return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
    endfunction

    // called and returns at a falling edge
    task automatic push_sample(input logic [wlpd_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        items_sent = items_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic set_levels(input logic [wlpd_pkg::LEVEL_W-1:0] act,
                              input logic [wlpd_pkg::LEVEL_W-1:0] inact);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wlpd_pkg::CFG_ACTIVE_LEVEL;
        i_cfg_data <= act;
        @(negedge i_clk);
        i_cfg_idx  <= wlpd_pkg::CFG_INACTIVE_LEVEL;
        i_cfg_data <= inact;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_act    = act;
        cur_inact  = inact;
    endtask

    // hold requests until every result is back, then let the pipeline drain
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : result_pacing
        int  busy;
        int  hold;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        state_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && items_sent >= STALL_AT) begin
                // hold off while requests keep coming so the block backs up
                long_hold_done = 1'b1;
                state_ch.ready <= 1'b0;
                hold = 0;
                while (hold < STALL_CYCLES) begin
                    @(negedge i_clk);
                    hold = hold + 1;
                end
            end else begin
                busy = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
                state_ch.ready <= 1'b1;
                repeat (busy) @(negedge i_clk);
                hold = pick_gap();
                if (hold > 0) begin
                    state_ch.ready <= 1'b0;
                    repeat (hold) @(negedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= wlpd_pkg::CFG_ACTIVE_LEVEL;
        i_cfg_data       <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_levels(wlpd_pkg::ACTIVE_LEVEL_RST, wlpd_pkg::INACTIVE_LEVEL_RST);

        // full-scale samples: no move while filling, active once full,
        // then zeros pull the average down into the noise band
        for (n = 0; n < 16; n++) push_sample(12'hFFF);
        for (n = 0; n < 9; n++) push_sample(12'h000);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            if (phase < 6) begin
                set_levels(ACT_SET[phase], INACT_SET[phase]);
            end else begin
                set_levels(wlpd_pkg::LEVEL_W'($urandom_range(0, 4095)),
                           wlpd_pkg::LEVEL_W'($urandom_range(0, 4095)));
            end
            run_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++) push_sample(next_level());
        end

        drain();
        if (miss_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/wlpd_pkg.sv
src/wlpd_if.sv
src/windowed_level_presence_detector_unit.sv
sim/wlpd_presence_monitor.sv
sim/windowed_level_presence_detector_unit_tb.sv
